// ===== design/point_in_triangle_ray_cast_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-triangle block
// Shared property shorthands, all clocked on i_clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_RAY_CAST_MACROS_SVH
`define POINT_IN_TRIANGLE_RAY_CAST_MACROS_SVH

// implication checked at every clock edge outside reset
`define PITR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define PITR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/pitr_pkg.sv =====
// ----------------------------------------------------------------------------
// pitr_pkg
// Types and register indexes of the point-in-triangle block.
// ----------------------------------------------------------------------------
`default_nettype none
package pitr_pkg;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_V0X = 3'd0,
        REG_V0Y = 3'd1,
        REG_V1X = 3'd2,
        REG_V1Y = 3'd3,
        REG_V2X = 3'd4,
        REG_V2Y = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] crossings;
    } t_out_word;
endpackage
`default_nettype wire

// ===== design/point_in_triangle_ray_cast.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_ray_cast
// Ray-cast point-in-triangle test against three Q16.16 vertex registers.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  in       | i_in_valid / o_in_ready   | i_in_data  (t_in_word)
//  out      | o_out_valid / i_out_ready | o_out_data (t_out_word)
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle sustained when the output is not stalled; four register
//  stages, and a result is valid once its word has passed through all four.
//  Stage 1 forms differences and edge tests, stage 2 the 33x33 products,
//  stage 3 the product compare, stage 4 the vertex correction and count.
//  A stall holds each full stage with no empty stage after it; an empty stage fills while held.
//  Reset is synchronous and clears valid bits and vertices.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_triangle_ray_cast_macros.svh"
module point_in_triangle_ray_cast
    import pitr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_word           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    logic signed [31:0] r_vx [3];
    logic signed [31:0] r_vy [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_vx[j] <= '0;
                r_vy[j] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_V0X: r_vx[0] <= i_cfg_data;
                REG_V0Y: r_vy[0] <= i_cfg_data;
                REG_V1X: r_vx[1] <= i_cfg_data;
                REG_V1Y: r_vy[1] <= i_cfg_data;
                REG_V2X: r_vx[2] <= i_cfg_data;
                REG_V2Y: r_vy[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: stage k advances when the next one can take it
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    assign en4 = !r_v4 || i_out_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: box, per-edge prefilter, differences
    // edge j joins vertex a=(j+2)%3 and b=j, reordered so that ay <= by
    logic signed [31:0] px, py;
    assign px = i_in_data.point_x;
    assign py = i_in_data.point_y;

    logic              inbox;
    logic [2:0]        pre_ok, pre_vert;
    logic signed [32:0] d_pa [3]; // py - ay
    logic signed [32:0] d_ba [3]; // bx - ax
    logic signed [32:0] d_xa [3]; // px - ax
    logic signed [32:0] d_yy [3]; // by - ay
    logic [2:0]        yeq;       // vertex y equals point y
    logic [2:0]        extr;      // vertex is a y extremum

    always_comb begin
        logic signed [31:0] xmin, xmax, ymin, ymax, ax, ay, bx, by;
        xmin = r_vx[0]; xmax = r_vx[0]; ymin = r_vy[0]; ymax = r_vy[0];
        for (int j = 1; j < 3; j++) begin
            if (r_vx[j] < xmin) xmin = r_vx[j];
            if (r_vx[j] > xmax) xmax = r_vx[j];
            if (r_vy[j] < ymin) ymin = r_vy[j];
            if (r_vy[j] > ymax) ymax = r_vy[j];
        end
        inbox = !(px < xmin || px > xmax || py < ymin || py > ymax);
        for (int j = 0; j < 3; j++) begin
            ax = r_vx[(j+2)%3]; ay = r_vy[(j+2)%3];
            bx = r_vx[j];       by = r_vy[j];
            pre_ok[j] = !(ay == by) && !((ay > py && by > py) || (ay < py && by < py))
                        && !(ax < px && bx < px);
            pre_vert[j] = (ax == bx);
            if (by < ay) begin
                ax = r_vx[j];       ay = r_vy[j];
                bx = r_vx[(j+2)%3]; by = r_vy[(j+2)%3];
            end
            d_pa[j] = 33'(py) - 33'(ay);
            d_ba[j] = 33'(bx) - 33'(ax);
            d_xa[j] = 33'(px) - 33'(ax);
            d_yy[j] = 33'(by) - 33'(ay);
            yeq[j]  = (r_vy[j] == py);
            extr[j] = (r_vy[(j+2)%3] < r_vy[j] && r_vy[(j+1)%3] < r_vy[j]) ||
                      (r_vy[(j+2)%3] > r_vy[j] && r_vy[(j+1)%3] > r_vy[j]);
        end
    end

    logic               r1_inbox;
    logic [2:0]         r1_ok, r1_vert, r1_yeq, r1_extr;
    logic signed [32:0] r1_pa [3], r1_ba [3], r1_xa [3], r1_yy [3];
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_inbox <= inbox;
            r1_ok    <= pre_ok;
            r1_vert  <= pre_vert;
            r1_yeq   <= yeq;
            r1_extr  <= extr;
            for (int j = 0; j < 3; j++) begin
                r1_pa[j] <= d_pa[j];
                r1_ba[j] <= d_ba[j];
                r1_xa[j] <= d_xa[j];
                r1_yy[j] <= d_yy[j];
            end
        end
    end

    // ---- stage 2: products
    logic               r2_inbox;
    logic [2:0]         r2_ok, r2_vert, r2_yeq, r2_extr;
    logic signed [65:0] r2_p [3], r2_q [3];
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_inbox <= r1_inbox;
            r2_ok    <= r1_ok;
            r2_vert  <= r1_vert;
            r2_yeq   <= r1_yeq;
            r2_extr  <= r1_extr;
            for (int j = 0; j < 3; j++) begin
                r2_p[j] <= r1_pa[j] * r1_ba[j];
                r2_q[j] <= r1_xa[j] * r1_yy[j];
            end
        end
    end

    // ---- stage 3: compare, edge hits
    logic [2:0] hit;
    always_comb begin
        for (int j = 0; j < 3; j++)
            hit[j] = r2_ok[j] && (r2_vert[j] || (r2_p[j] >= r2_q[j]));
    end

    logic       r3_inbox;
    logic [2:0] r3_hit, r3_yeq, r3_extr;
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_inbox <= r2_inbox;
            r3_hit   <= hit;
            r3_yeq   <= r2_yeq;
            r3_extr  <= r2_extr;
        end
    end

    // ---- stage 4: vertex correction and count
    logic [1:0] cnt;
    always_comb begin
        logic [2:0] hits, drops;
        hits = 3'(r3_hit[0]) + 3'(r3_hit[1]) + 3'(r3_hit[2]);
        drops = '0;
        for (int k = 0; k < 3; k++)
            if (r3_hit[k] && r3_hit[(k+1)%3] && r3_yeq[k] && !r3_extr[k])
                drops = drops + 3'd1;
        if (!r3_inbox || drops > hits) cnt = '0;
        else cnt = 2'(hits - drops);
    end

    t_out_word r4_out;
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_out.crossings  <= cnt;
            r4_out.inside_res <= cnt[0];
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r4_out;

    `PITR_ASSERT_IMP(a_res_par, o_out_valid, o_out_data.inside_res == o_out_data.crossings[0])
    `PITR_ASSERT_NXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `PITR_ASSERT_NXT(a_fill, i_in_valid && o_in_ready, r_v1)
endmodule
`default_nettype wire

// ===== bench/point_in_triangle_ray_cast_tb.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_ray_cast_tb
// Drives query points against several triangles, random and degenerate, and
// checks the inside flag and crossing count of every result word against a
// predictor that works the ray cast out with exact wide products.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module point_in_triangle_ray_cast_tb;
    import pitr_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_word           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_word          o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0]        i_cfg_data;

    point_in_triangle_ray_cast DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic signed [31:0] tri_x [3];
    logic signed [31:0] tri_y [3];

    t_in_word  point_queue [$];
    t_out_word verdict_queue [$];
    int        mismatch_count;
    int        in_gap;
    int        out_gap;
    bit        point_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // a*b - c*d >= 0, all operands within 35 bits
    function automatic bit cross_ge(logic signed [63:0] a, logic signed [63:0] b,
                                    logic signed [63:0] c, logic signed [63:0] d);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = 128'(a) * 128'(b);
        q = 128'(c) * 128'(d);
        return (p - q) >= 0;
    endfunction

    function automatic bit ray_hits(logic signed [63:0] ax, logic signed [63:0] ay,
                                    logic signed [63:0] bx, logic signed [63:0] by,
                                    logic signed [63:0] px, logic signed [63:0] py);
        logic signed [63:0] t;
        if (ay == by) return 1'b0;
        if ((ay > py && by > py) || (ay < py && by < py)) return 1'b0;
        if (ax < px && bx < px) return 1'b0;
        if (ax == bx) return 1'b1;
        if (by < ay) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        return cross_ge(py - ay, bx - ax, px - ax, by - ay);
    endfunction

    function automatic t_out_word classify_point(t_in_word p);
        logic signed [63:0] vx [3];
        logic signed [63:0] vy [3];
        logic signed [63:0] px, py, xmin, xmax, ymin, ymax;
        bit   hit [3];
        bit   peak;
        int   count;
        int   prv;
        int   nxt;
        t_out_word r;
        r = '0;
        count = 0;
        px = 64'(p.point_x);
        py = 64'(p.point_y);
        for (int j = 0; j < 3; j++) begin
            vx[j] = 64'(tri_x[j]);
            vy[j] = 64'(tri_y[j]);
        end
        xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
        for (int j = 1; j < 3; j++) begin
            if (vx[j] < xmin) xmin = vx[j];
            if (vx[j] > xmax) xmax = vx[j];
            if (vy[j] < ymin) ymin = vy[j];
            if (vy[j] > ymax) ymax = vy[j];
        end
        if (px < xmin || px > xmax || py < ymin || py > ymax) return r;
        for (int j = 0; j < 3; j++) begin
            prv = (j + 2) % 3;
            hit[j] = ray_hits(vx[prv], vy[prv], vx[j], vy[j], px, py);
            if (hit[j]) count++;
        end
        // drop the double count at a vertex on the ray that is not a y extremum
        for (int k = 0; k < 3; k++) begin
            prv = (k + 2) % 3;
            nxt = (k + 1) % 3;
            if (hit[k] && hit[nxt] && vy[k] == py) begin
                peak = (vy[prv] < vy[k] && vy[nxt] < vy[k]) ||
                       (vy[prv] > vy[k] && vy[nxt] > vy[k]);
                if (!peak) count--;
            end
        end
        if (count < 0) count = 0;
        r.inside_res = count[0];
        r.crossings  = count[1:0];
        return r;
    endfunction

    // driver: next point word from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the word
        end else begin
            if (i_in_valid) verdict_queue = {verdict_queue, classify_point(i_in_data)};
            if (in_gap > 0 || point_hold || point_queue.size() == 0) begin
                i_in_valid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= point_queue.pop_front();
                in_gap     <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %p", o_out_data);
                end else begin
                    t_out_word e;
                    e = verdict_queue.pop_front();
                    if (e.inside_res !== o_out_data.inside_res ||
                        e.crossings !== o_out_data.crossings) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: expected inside=%0d crossings=%0d,",
                                      " got inside=%0d crossings=%0d"},
                                     e.inside_res, e.crossings,
                                     o_out_data.inside_res, o_out_data.crossings);
                    end
                end
            end
            if (out_gap > 0) begin
                i_out_ready <= 1'b0;
                out_gap     <= out_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
                out_gap     <= pick_gap();
            end
        end
    end

    // hold valid across back-to-back writes; the caller drops it
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_V0X: tri_x[0] = value;
            REG_V0Y: tri_y[0] = value;
            REG_V1X: tri_x[1] = value;
            REG_V1Y: tri_y[1] = value;
            REG_V2X: tri_x[2] = value;
            default: tri_y[2] = value;
        endcase
    endtask

    task automatic load_triangle(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                                 logic [31:0] y1, logic [31:0] x2, logic [31:0] y2);
        write_reg(REG_V0X, x0);
        write_reg(REG_V0Y, y0);
        write_reg(REG_V1X, x1);
        write_reg(REG_V1Y, y1);
        write_reg(REG_V2X, x2);
        write_reg(REG_V2Y, y2);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || i_in_valid || verdict_queue.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y);
        t_in_word w;
        w.point_x = x;
        w.point_y = y;
        point_queue = {point_queue, w};
    endtask

    // random coordinate: mostly in [lo,hi], sometimes full range
    function automatic logic [31:0] coord(int lo, int hi);
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic random_points(int n);
        int lo_x, hi_x, lo_y, hi_y;
        int sel;
        lo_x = tri_x[0]; hi_x = tri_x[0]; lo_y = tri_y[0]; hi_y = tri_y[0];
        for (int j = 1; j < 3; j++) begin
            if (tri_x[j] < lo_x) lo_x = tri_x[j];
            if (tri_x[j] > hi_x) hi_x = tri_x[j];
            if (tri_y[j] < lo_y) lo_y = tri_y[j];
            if (tri_y[j] > hi_y) hi_y = tri_y[j];
        end
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 2);
            // snap to a vertex y or vertex x now and then to hit the corners
            if (sel == 0)
                add_point(coord(lo_x, hi_x), tri_y[$urandom_range(0, 2)]);
            else if (sel == 1 && $urandom_range(0, 1))
                add_point(tri_x[$urandom_range(0, 2)], coord(lo_y, hi_y));
            else
                add_point(coord(lo_x, hi_x), coord(lo_y, hi_y));
        end
    endtask

    task automatic random_triangle(int span);
        int v [6];
        for (int j = 0; j < 6; j++) v[j] = int'($urandom_range(0, 2 * span)) - span;
        // share a y or an x between two vertices at times for horizontal or vertical edges
        if ($urandom_range(0, 3) == 0) v[3] = v[1];
        if ($urandom_range(0, 3) == 0) v[4] = v[2];
        load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        mismatch_count = 0;
        point_hold     = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_V0X;
        i_cfg_data     = '0;
        for (int j = 0; j < 3; j++) begin
            tri_x[j] = '0;
            tri_y[j] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset triangle is a single point at the origin
        add_point(32'h0, 32'h0);
        add_point(32'h1, 32'h0);
        drain();

        load_triangle(32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0005_0000, 32'h000a_0000);
        add_point(32'h0005_0000, 32'h0005_0000);   // inside
        add_point(32'h0, 32'h0);                   // on a vertex
        add_point(32'h0005_0000, 32'h0);           // on the horizontal edge
        add_point(32'h0005_0000, 32'h000a_0000);   // on the apex
        add_point(32'h0002_8000, 32'h0005_0000);   // on a slanted edge
        add_point(32'hffff_ffff, 32'h0005_0000);   // just left of box
        add_point(32'h7fff_ffff, 32'h8000_0000);   // extremes
        add_point(32'h8000_0000, 32'h7fff_ffff);
        add_point(32'h0000_0001, 32'h0000_0001);
        drain();

        // vertical edge, and vertex 0 on the ray not an extremum
        load_triangle(32'h0, 32'h0005_0000, 32'h000a_0000, 32'h0, 32'h000a_0000,
                      32'h000a_0000);
        add_point(32'h0, 32'h0005_0000);
        add_point(32'h0001_0000, 32'h0005_0000);
        add_point(32'h0008_0000, 32'h0005_0000);
        add_point(32'h000a_0000, 32'h0002_0000);
        add_point(32'h0008_0000, 32'h0);
        // pause the sender mid-stream until every verdict is back
        while (point_queue.size() > 2) @(posedge i_clk);
        point_hold = 1'b1;
        while (i_in_valid || verdict_queue.size() != 0) @(posedge i_clk);
        point_hold = 1'b0;
        drain();

        // extreme triangle spanning the full range
        load_triangle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h0, 32'h7fff_ffff);
        add_point(32'h0, 32'h0);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h7fff_ffff, 32'h7fff_ffff);
        add_point(32'hc000_0000, 32'h0);
        random_points(20);
        drain();

        // collinear degenerate triangle
        load_triangle(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                      32'h0002_0000);
        add_point(32'h0001_0000, 32'h0001_0000);
        add_point(32'h0000_8000, 32'h0001_0000);
        random_points(10);
        drain();

        for (int t = 0; t < 12; t++) begin
            if (t % 4 == 3) random_triangle(2000000000);
            else            random_triangle(int'($urandom_range(4, 400)));
            random_points(30);
            drain();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
